// ----- hw/rtl/ccsd_pkg.sv -----
// Shared types and constants for the character canvas span drawing engine.
`timescale 1ns / 1ps

package ccsd_pkg;

    localparam int COL_W = 6;
    localparam int ROW_W = 5;

    localparam logic [2:0] MODE_LINE  = 3'd0;
    localparam logic [2:0] MODE_RECT  = 3'd1;
    localparam logic [2:0] MODE_ERASE = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_DIAGONAL = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [7:0] BLANK_CHAR = 8'd32;

    typedef struct packed {
        logic [2:0]       mode;
        logic [COL_W-1:0] x_start;
        logic [ROW_W-1:0] y_start;
        logic [COL_W-1:0] x_end;
        logic [ROW_W-1:0] y_end;
        logic [7:0]       fill_char;
    } cmd_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [1:0] status;
    } rsp_t;

endpackage

// ----- hw/rtl/ccsd_mem.sv -----
// Single-port cell memory with a registered read.
`timescale 1ns / 1ps

module ccsd_mem #(
    parameter int DEPTH  = 1280,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem_array [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ccsd_ctl.sv -----
// Command sequencer: range checks, span walking, clearing sweep and result register.
`timescale 1ns / 1ps

module ccsd_ctl #(
    parameter int CANVAS_ROWS = 20,
    parameter int CANVAS_COLS = 40,
    parameter int ROW_B       = 5,
    parameter int COL_B       = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  ccsd_pkg::cmd_t          cmd,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output ccsd_pkg::rsp_t          rsp,
    output logic                    mem_we,
    output logic                    mem_re,
    output logic [ROW_B+COL_B-1:0]  mem_addr,
    output logic [7:0]              mem_wdata,
    input  logic [7:0]              mem_rdata
);

    localparam int ADDR_W = ROW_B + COL_B;
    localparam logic [ccsd_pkg::COL_W:0] COLS_LIM = (ccsd_pkg::COL_W + 1)'(CANVAS_COLS);
    localparam logic [ccsd_pkg::ROW_W:0] ROWS_LIM = (ccsd_pkg::ROW_W + 1)'(CANVAS_ROWS);
    localparam logic [ccsd_pkg::COL_W-1:0] LAST_COL = (ccsd_pkg::COL_W)'(CANVAS_COLS - 1);
    localparam logic [ccsd_pkg::ROW_W-1:0] LAST_ROW = (ccsd_pkg::ROW_W)'(CANVAS_ROWS - 1);

    localparam logic [1:0] SPAN_TOP    = 2'd0;
    localparam logic [1:0] SPAN_LEFT   = 2'd1;
    localparam logic [1:0] SPAN_BOTTOM = 2'd2;
    localparam logic [1:0] SPAN_RIGHT  = 2'd3;

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SPAN   = 5'b00100,
        S_RDWAIT = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    typedef struct packed {
        logic                        vert;
        logic [ccsd_pkg::COL_W-1:0]  fixed;
        logic [ccsd_pkg::COL_W-1:0]  lo;
        logic [ccsd_pkg::COL_W-1:0]  hi;
    } span_t;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ccsd_pkg::ROW_W-1:0] row,
        input logic [ccsd_pkg::COL_W-1:0] col
    );
        cell_addr = {row[ROW_B-1:0], col[COL_B-1:0]};
    endfunction

    // The four outline spans of a box; a straight line is the same box with zero height or zero width.
    function automatic span_t span_setup(input ccsd_pkg::cmd_t c, input logic [1:0] idx);
        logic [ccsd_pkg::COL_W-1:0] ys6;
        logic [ccsd_pkg::COL_W-1:0] ye6;
        logic [ccsd_pkg::COL_W-1:0] xlo;
        logic [ccsd_pkg::COL_W-1:0] xhi;
        logic [ccsd_pkg::COL_W-1:0] ylo;
        logic [ccsd_pkg::COL_W-1:0] yhi;
        span_t s;
        ys6 = {1'b0, c.y_start};
        ye6 = {1'b0, c.y_end};
        xlo = (c.x_start < c.x_end) ? c.x_start : c.x_end;
        xhi = (c.x_start < c.x_end) ? c.x_end : c.x_start;
        ylo = (ys6 < ye6) ? ys6 : ye6;
        yhi = (ys6 < ye6) ? ye6 : ys6;
        unique case (idx)
            SPAN_TOP:    s = '{vert: 1'b0, fixed: ys6, lo: xlo, hi: xhi};
            SPAN_LEFT:   s = '{vert: 1'b1, fixed: c.x_start, lo: ylo, hi: yhi};
            SPAN_BOTTOM: s = '{vert: 1'b0, fixed: ye6, lo: xlo, hi: xhi};
            SPAN_RIGHT:  s = '{vert: 1'b1, fixed: c.x_end, lo: ylo, hi: yhi};
            default:     s = '{vert: 1'b0, fixed: ys6, lo: xlo, hi: xhi};
        endcase
        span_setup = s;
    endfunction

    state_t                       state_reg, state_next;
    ccsd_pkg::cmd_t               cmd_reg, cmd_next;
    ccsd_pkg::rsp_t               res_reg, res_next;
    ccsd_pkg::rsp_t               rsp_reg, rsp_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    logic                         clear_cmd_reg, clear_cmd_next;
    logic [ccsd_pkg::ROW_W-1:0]   sw_row_reg, sw_row_next;
    logic [ccsd_pkg::COL_W-1:0]   sw_col_reg, sw_col_next;
    logic [1:0]                   span_idx_reg, span_idx_next;
    span_t                        span_reg, span_next;
    logic [ccsd_pkg::COL_W-1:0]   cur_reg, cur_next;

    logic                         start_ok;
    logic                         end_ok;
    logic                         accept;
    span_t                        first_span;
    span_t                        follow_span;
    logic [ccsd_pkg::ROW_W-1:0]   span_row;
    logic [ccsd_pkg::COL_W-1:0]   span_col;

    assign start_ok = ({1'b0, cmd.x_start} < COLS_LIM) && ({1'b0, cmd.y_start} < ROWS_LIM);
    assign end_ok   = ({1'b0, cmd.x_end} < COLS_LIM) && ({1'b0, cmd.y_end} < ROWS_LIM);
    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign first_span  = span_setup(cmd, SPAN_TOP);
    assign follow_span = span_setup(cmd_reg, span_idx_reg + 2'd1);
    assign span_row = span_reg.vert ? cur_reg[ccsd_pkg::ROW_W-1:0]
                                    : span_reg.fixed[ccsd_pkg::ROW_W-1:0];
    assign span_col = span_reg.vert ? span_reg.fixed : cur_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        clear_cmd_next = clear_cmd_reg;
        sw_row_next    = sw_row_reg;
        sw_col_next    = sw_col_reg;
        span_idx_next  = span_idx_reg;
        span_next      = span_reg;
        cur_next       = cur_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = cell_addr(sw_row_reg, sw_col_reg);
        mem_wdata      = ccsd_pkg::BLANK_CHAR;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                if (sw_col_reg == LAST_COL)
                begin
                    sw_col_next = '0;
                    if (sw_row_reg == LAST_ROW)
                    begin
                        sw_row_next = '0;
                        state_next  = clear_cmd_reg ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        sw_row_next = sw_row_reg + 1'b1;
                    end
                end
                else
                begin
                    sw_col_next = sw_col_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd;
                    res_next = '{cell_char: 8'd0, status: ccsd_pkg::ST_DONE};
                    state_next = S_DONE;
                    mem_addr = cell_addr(cmd.y_start, cmd.x_start);
                    unique case (cmd.mode)
                        ccsd_pkg::MODE_LINE, ccsd_pkg::MODE_RECT:
                        begin
                            if (!start_ok || !end_ok)
                            begin
                                res_next.status = ccsd_pkg::ST_RANGE;
                            end
                            else if (cmd.mode == ccsd_pkg::MODE_LINE
                                     && cmd.x_start != cmd.x_end
                                     && cmd.y_start != cmd.y_end)
                            begin
                                res_next.status = ccsd_pkg::ST_DIAGONAL;
                            end
                            else
                            begin
                                span_idx_next = SPAN_TOP;
                                span_next     = first_span;
                                cur_next      = first_span.lo;
                                state_next    = S_SPAN;
                            end
                        end
                        ccsd_pkg::MODE_ERASE:
                        begin
                            if (!start_ok)
                            begin
                                res_next.status = ccsd_pkg::ST_RANGE;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                            end
                        end
                        ccsd_pkg::MODE_CLEAR:
                        begin
                            clear_cmd_next = 1'b1;
                            sw_row_next    = '0;
                            sw_col_next    = '0;
                            state_next     = S_INIT;
                        end
                        ccsd_pkg::MODE_READ:
                        begin
                            if (!start_ok)
                            begin
                                res_next.status = ccsd_pkg::ST_RANGE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_RDWAIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SPAN:
            begin
                mem_we    = 1'b1;
                mem_addr  = cell_addr(span_row, span_col);
                mem_wdata = cmd_reg.fill_char;
                if (cur_reg == span_reg.hi)
                begin
                    if (span_idx_reg == SPAN_RIGHT)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        span_idx_next = span_idx_reg + 2'd1;
                        span_next     = follow_span;
                        cur_next      = follow_span.lo;
                    end
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            S_RDWAIT:
            begin
                res_next.cell_char = mem_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rsp_valid_reg <= 1'b0;
            clear_cmd_reg <= 1'b0;
            sw_row_reg    <= '0;
            sw_col_reg    <= '0;
            span_idx_reg  <= SPAN_TOP;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            clear_cmd_reg <= clear_cmd_next;
            sw_row_reg    <= sw_row_next;
            sw_col_reg    <= sw_col_next;
            span_idx_reg  <= span_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
        span_reg <= span_next;
        cur_reg  <= cur_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("Memory read and write issued in the same cycle.");

    a_span_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPAN) |-> (cur_reg <= span_reg.hi))
        else $error("Span cursor ran past the span end.");

    a_read_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDWAIT) |=> (state_reg == S_DONE))
        else $error("Read did not complete after one wait cycle.");

    a_beat_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("Result beat raised outside the completion state.");

endmodule

// ----- hw/rtl/char_canvas_span_draw.sv -----
// Top level of the character canvas span drawing engine.
`timescale 1ns / 1ps

// Usage:
// Commands enter on the cmd channel (cmd_valid/cmd_ready) and each gives one
// result beat on the rsp channel (rsp_valid/rsp_ready) with the cell byte and a status.
// The canvas lives in one single-port memory that is written one cell per cycle.
// A line or rectangle is drawn as its four outline spans in turn (top, left, bottom, right),
// so every cell of a line is written more than once.
// Erase, rejected and unused commands go straight to the result state; a read first
// passes a wait state, because the memory read data is registered.
// A clear sweeps every cell, row by row.
// The block works on one command at a time; cmd_ready is high only when it is idle.
// After reset the same sweep fills the canvas with spaces before cmd_ready first rises.
// The result register holds a beat while the receiver stalls; the next command is
// still accepted and its result waits until the register frees.
module char_canvas_span_draw #(
    parameter int CANVAS_ROWS = 20,
    parameter int CANVAS_COLS = 40
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  ccsd_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ccsd_pkg::rsp_t rsp
);

    localparam int ROW_B  = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
    localparam int COL_B  = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
    localparam int ADDR_W = ROW_B + COL_B;
    localparam int DEPTH  = CANVAS_ROWS * (2 ** COL_B);

    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;

    ccsd_ctl #(
        .CANVAS_ROWS (CANVAS_ROWS),
        .CANVAS_COLS (CANVAS_COLS),
        .ROW_B       (ROW_B),
        .COL_B       (COL_B)
    ) u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    ccsd_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the character canvas span drawing engine against a shadow canvas.
`timescale 1ns / 1ps

module tb_top;

    localparam int ROWS           = 20;
    localparam int COLS           = 40;
    localparam int MAX_COL        = (1 << ccsd_pkg::COL_W) - 1;
    localparam int MAX_ROW        = (1 << ccsd_pkg::ROW_W) - 1;
    localparam int RANDOM_ITEMS   = 525;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = ROWS * COLS + 16;

    localparam logic [2:0] MODE_SPARE_A = 3'd5;
    localparam logic [2:0] MODE_SPARE_B = 3'd6;
    localparam logic [2:0] MODE_SPARE_C = 3'd7;

    class canvas_shadow;
        logic [7:0]     cells [ROWS][COLS];
        ccsd_pkg::rsp_t owed_rsp [$];
        int             errors;

        function new();
            errors = 0;
            blank_all();
        endfunction

        function void blank_all();
            foreach (cells[r, c])
                cells[r][c] = ccsd_pkg::BLANK_CHAR;
        endfunction

        function bit in_range(int col, int row);
            return col < COLS && row < ROWS;
        endfunction

        function void fill_span(int c0, int r0, int c1, int r1, logic [7:0] ch);
            int lo;
            int hi;
            if (c0 == c1)
            begin
                lo = (r0 < r1) ? r0 : r1;
                hi = (r0 < r1) ? r1 : r0;
                for (int k = lo; k <= hi; k++)
                    cells[k][c0] = ch;
            end
            else
            begin
                lo = (c0 < c1) ? c0 : c1;
                hi = (c0 < c1) ? c1 : c0;
                for (int k = lo; k <= hi; k++)
                    cells[r0][k] = ch;
            end
        endfunction

        function void log_command(ccsd_pkg::cmd_t c);
            ccsd_pkg::rsp_t want;
            int   xs;
            int   ys;
            int   xe;
            int   ye;
            xs = int'(c.x_start);
            ys = int'(c.y_start);
            xe = int'(c.x_end);
            ye = int'(c.y_end);
            want.cell_char = 8'd0;
            want.status    = ccsd_pkg::ST_DONE;
            case (c.mode)
                ccsd_pkg::MODE_LINE:
                begin
                    if (!in_range(xs, ys) || !in_range(xe, ye))
                        want.status = ccsd_pkg::ST_RANGE;
                    else if (xs != xe && ys != ye)
                        want.status = ccsd_pkg::ST_DIAGONAL;
                    else
                        fill_span(xs, ys, xe, ye, c.fill_char);
                end
                ccsd_pkg::MODE_RECT:
                begin
                    if (!in_range(xs, ys) || !in_range(xe, ye))
                        want.status = ccsd_pkg::ST_RANGE;
                    else
                    begin
                        fill_span(xs, ys, xe, ys, c.fill_char);
                        fill_span(xs, ys, xs, ye, c.fill_char);
                        fill_span(xs, ye, xe, ye, c.fill_char);
                        fill_span(xe, ys, xe, ye, c.fill_char);
                    end
                end
                ccsd_pkg::MODE_ERASE:
                begin
                    if (!in_range(xs, ys))
                        want.status = ccsd_pkg::ST_RANGE;
                    else
                        cells[ys][xs] = ccsd_pkg::BLANK_CHAR;
                end
                ccsd_pkg::MODE_CLEAR:
                    blank_all();
                ccsd_pkg::MODE_READ:
                begin
                    if (!in_range(xs, ys))
                        want.status = ccsd_pkg::ST_RANGE;
                    else
                        want.cell_char = cells[ys][xs];
                end
                default:
                    ;
            endcase
            owed_rsp.push_back(want);
        endfunction

        function void check_rsp(ccsd_pkg::rsp_t got);
            ccsd_pkg::rsp_t want;
            if (owed_rsp.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: cell_char=%0d status=%0d",
                             got.cell_char, got.status);
                return;
            end
            want = owed_rsp.pop_front();
            if (got.cell_char !== want.cell_char || got.status !== want.status)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %0d/%0d, got %0d/%0d (cell_char/status)",
                             want.cell_char, want.status, got.cell_char, got.status);
            end
        endfunction

        function int pending();
            return owed_rsp.size();
        endfunction
    endclass

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_ready;
    ccsd_pkg::cmd_t cmd       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    ccsd_pkg::rsp_t rsp;

    bit           idle_on = 1'b1;
    canvas_shadow shadow  = new();

    char_canvas_span_draw #(
        .CANVAS_ROWS(ROWS),
        .CANVAS_COLS(COLS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ccsd_pkg::COL_W-1:0] pick_col();
        if ($urandom_range(0, 19) == 0)
            return (ccsd_pkg::COL_W)'($urandom_range(COLS, MAX_COL));
        return (ccsd_pkg::COL_W)'($urandom_range(0, COLS - 1));
    endfunction

    function automatic logic [ccsd_pkg::ROW_W-1:0] pick_row();
        if ($urandom_range(0, 19) == 0)
            return (ccsd_pkg::ROW_W)'($urandom_range(ROWS, MAX_ROW));
        return (ccsd_pkg::ROW_W)'($urandom_range(0, ROWS - 1));
    endfunction

    function automatic ccsd_pkg::cmd_t make_cmd(logic [2:0] mode, int xs, int ys,
                                                int xe, int ye, int ch);
        ccsd_pkg::cmd_t c;
        c.mode      = mode;
        c.x_start   = (ccsd_pkg::COL_W)'(xs);
        c.y_start   = (ccsd_pkg::ROW_W)'(ys);
        c.x_end     = (ccsd_pkg::COL_W)'(xe);
        c.y_end     = (ccsd_pkg::ROW_W)'(ye);
        c.fill_char = 8'(ch);
        return c;
    endfunction

    function automatic ccsd_pkg::cmd_t random_cmd();
        ccsd_pkg::cmd_t c;
        int   pick;
        int   shape;
        pick        = $urandom_range(0, 99);
        shape       = $urandom_range(0, 9);
        c.x_start   = pick_col();
        c.y_start   = pick_row();
        c.x_end     = pick_col();
        c.y_end     = pick_row();
        c.fill_char = 8'($urandom_range(0, 255));
        if (pick < 32)
        begin
            c.mode = ccsd_pkg::MODE_LINE;
            if (shape < 6)
                c.y_end = c.y_start;
            else if (shape < 9)
                c.x_end = c.x_start;
        end
        else if (pick < 48)
            c.mode = ccsd_pkg::MODE_RECT;
        else if (pick < 88)
        begin
            c.mode  = (pick < 58) ? ccsd_pkg::MODE_ERASE : ccsd_pkg::MODE_READ;
            c.x_end = (ccsd_pkg::COL_W)'($urandom_range(0, MAX_COL));
            c.y_end = (ccsd_pkg::ROW_W)'($urandom_range(0, MAX_ROW));
        end
        else if (pick < 91)
            c.mode = ccsd_pkg::MODE_CLEAR;
        else if (pick < 94)
            c.mode = 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
        else
        begin
            c.mode    = 3'($urandom_range(0, 7));
            c.x_start = (ccsd_pkg::COL_W)'($urandom_range(0, MAX_COL));
            c.y_start = (ccsd_pkg::ROW_W)'($urandom_range(0, MAX_ROW));
            c.x_end   = (ccsd_pkg::COL_W)'($urandom_range(0, MAX_COL));
            c.y_end   = (ccsd_pkg::ROW_W)'($urandom_range(0, MAX_ROW));
        end
        return c;
    endfunction

    task automatic send_cmd(input ccsd_pkg::cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (!cmd_ready);
        shadow.log_command(c);
    endtask

    task automatic wait_all_returned();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (shadow.pending() != 0);
    endtask

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                shadow.check_rsp(rsp);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_cmd(make_cmd(ccsd_pkg::MODE_READ, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ccsd_pkg::MODE_READ, COLS - 1, ROWS - 1, MAX_COL, MAX_ROW, 255));
        send_cmd(make_cmd(ccsd_pkg::MODE_LINE, 0, 0, COLS - 1, 0, 255));
        send_cmd(make_cmd(ccsd_pkg::MODE_LINE, COLS - 1, ROWS - 1, COLS - 1, 0, 0));
        send_cmd(make_cmd(ccsd_pkg::MODE_LINE, 5, 5, 5, 5, 65));
        send_cmd(make_cmd(ccsd_pkg::MODE_LINE, 1, 1, 3, 4, 66));
        send_cmd(make_cmd(ccsd_pkg::MODE_LINE, COLS, 1, 3, 4, 67));
        send_cmd(make_cmd(ccsd_pkg::MODE_LINE, 0, 0, 0, MAX_ROW, 68));
        send_cmd(make_cmd(ccsd_pkg::MODE_LINE, MAX_COL, MAX_ROW, MAX_COL, MAX_ROW, 69));
        send_cmd(make_cmd(ccsd_pkg::MODE_RECT, 2, 3, 10, 8, 82));
        send_cmd(make_cmd(ccsd_pkg::MODE_RECT, 30, 15, 20, 10, 81));
        send_cmd(make_cmd(ccsd_pkg::MODE_RECT, 7, 2, 7, 12, 124));
        send_cmd(make_cmd(ccsd_pkg::MODE_RECT, 12, 17, 25, 17, 45));
        send_cmd(make_cmd(ccsd_pkg::MODE_RECT, 33, 6, 33, 6, 42));
        send_cmd(make_cmd(ccsd_pkg::MODE_RECT, 0, 0, COLS, ROWS - 1, 43));
        send_cmd(make_cmd(ccsd_pkg::MODE_ERASE, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ccsd_pkg::MODE_ERASE, MAX_COL, MAX_ROW, 0, 0, 0));
        send_cmd(make_cmd(ccsd_pkg::MODE_READ, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ccsd_pkg::MODE_READ, 20, 12, 0, 0, 0));
        send_cmd(make_cmd(ccsd_pkg::MODE_READ, 5, 5, 0, 0, 0));
        send_cmd(make_cmd(ccsd_pkg::MODE_READ, COLS, ROWS - 1, 0, 0, 0));
        send_cmd(make_cmd(MODE_SPARE_A, 3, 3, 9, 3, 170));
        send_cmd(make_cmd(MODE_SPARE_B, MAX_COL, MAX_ROW, MAX_COL, MAX_ROW, 85));
        send_cmd(make_cmd(MODE_SPARE_C, 0, 0, 0, 0, 255));
        send_cmd(make_cmd(ccsd_pkg::MODE_CLEAR, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ccsd_pkg::MODE_READ, COLS - 1, 0, 0, 0, 0));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_on = !(n >= 150 && n < 220);
            if (n == 300)
                wait_all_returned();
            send_cmd(random_cmd());
        end

        wait_all_returned();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
